@@ hdl/tksel_pkg.sv @@
package tksel_pkg;

  // fixed field widths
  localparam int unsigned ScoreWidth = 32;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned TagPortW   = 32;
  localparam int unsigned IndexWidth = 4;
  localparam int unsigned PosWidth   = 4;
  localparam int unsigned CountWidth = 5;

  // parameter defaults
  localparam int unsigned CapacityDef = 16;
  localparam int unsigned TagWidthDef = 32;

  // item operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } tksel_cmd_t;

  // true if (s1,k1) ranks strictly ahead of (s2,k2)
  function automatic logic ranks_before(input logic [ScoreWidth-1:0] s1,
                                        input logic [KeyWidth-1:0]   k1,
                                        input logic [ScoreWidth-1:0] s2,
                                        input logic [KeyWidth-1:0]   k2);
    logic res;
    res = (s1 < s2) || ((s1 == s2) && (k1 < k2));
    return res;
  endfunction

endpackage

@@ hdl/tksel_ctrl.sv @@
module tksel_ctrl
  import tksel_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tksel_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          in_ready_d = 1'b0;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          in_ready_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d     = S_IDLE;
        in_ready_d  = 1'b1;
        out_valid_d = 1'b0;
      end
    endcase
  end

  // state and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/tksel_dp.sv @@
module tksel_dp
  import tksel_pkg::*;
#(
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned TAG_WIDTH = TagWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tksel_cmd_t            cmd_i,
  input  logic                  op_i,
  input  logic [ScoreWidth-1:0] score_i,
  input  logic [KeyWidth-1:0]   key_i,
  input  logic [TagPortW-1:0]   tag_i,
  input  logic [IndexWidth-1:0] index_i,
  output logic                  accepted_o,
  output logic [PosWidth-1:0]   position_o,
  output logic [CountWidth-1:0] count_o,
  output logic                  present_o,
  output logic [ScoreWidth-1:0] entry_score_o,
  output logic [KeyWidth-1:0]   entry_key_o,
  output logic [TagPortW-1:0]   entry_tag_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // captured transaction
  op_e                   op_q;
  logic [ScoreWidth-1:0] score_q;
  logic [KeyWidth-1:0]   key_q;
  logic [TAG_WIDTH-1:0]  tag_q;
  logic [IndexWidth-1:0] index_q;

  // sorted slot row and fill count
  logic [ScoreWidth-1:0] slot_score_q [CAPACITY];
  logic [KeyWidth-1:0]   slot_key_q   [CAPACITY];
  logic [TAG_WIDTH-1:0]  slot_tag_q   [CAPACITY];
  logic [CntW-1:0]       count_q;

  // compare stage results
  logic [CAPACITY-1:0]   lt_q, lt_d;
  logic                  hit_q, hit_d;
  logic [ScoreWidth-1:0] rd_score_q, rd_score_d;
  logic [KeyWidth-1:0]   rd_key_q, rd_key_d;
  logic [TAG_WIDTH-1:0]  rd_tag_q, rd_tag_d;

  // result registers
  logic                  accepted_q;
  logic [PosWidth-1:0]   position_q;
  logic                  present_q;
  logic [ScoreWidth-1:0] entry_score_q;
  logic [KeyWidth-1:0]   entry_key_q;
  logic [TAG_WIDTH-1:0]  entry_tag_q;

  // update stage decisions
  logic            full;
  logic            ins;
  logic [IdxW-1:0] pos;

  // capture input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      score_q <= score_i;
      key_q   <= key_i;
      tag_q   <= TAG_WIDTH'(tag_i);
      index_q <= index_i;
    end
  end

  // per-slot rank compare and read select
  always_comb begin
    lt_d       = '0;
    rd_score_d = '0;
    rd_key_d   = '0;
    rd_tag_d   = '0;
    hit_d      = (32'(index_q) < 32'(count_q));
    for (int i = 0; i < CAPACITY; i++) begin
      lt_d[i] = (CntW'(i) < count_q) &&
                ranks_before(score_q, key_q, slot_score_q[i], slot_key_q[i]);
      if (32'(index_q) == i) begin
        rd_score_d = slot_score_q[i];
        rd_key_d   = slot_key_q[i];
        rd_tag_d   = slot_tag_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      lt_q       <= lt_d;
      hit_q      <= hit_d;
      rd_score_q <= rd_score_d;
      rd_key_q   <= rd_key_d;
      rd_tag_q   <= rd_tag_d;
    end
  end

  // insert slot: first entry ranked behind the new one, else the tail
  always_comb begin
    full = (count_q == CntW'(CAPACITY));
    ins  = !full || lt_q[CAPACITY-1];
    pos  = IdxW'(count_q);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (lt_q[i]) begin
        pos = IdxW'(i);
      end
    end
  end

  // shift the slot row open at the insert slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && (op_q == OP_INSERT) && ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IdxW'(i) == pos) begin
          slot_score_q[i] <= score_q;
          slot_key_q[i]   <= key_q;
          slot_tag_q[i]   <= tag_q;
        end else if ((i > 0) && (IdxW'(i) > pos)) begin
          slot_score_q[i] <= slot_score_q[(i > 0) ? i - 1 : 0];
          slot_key_q[i]   <= slot_key_q[(i > 0) ? i - 1 : 0];
          slot_tag_q[i]   <= slot_tag_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.update && (op_q == OP_INSERT) && !full) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (op_q == OP_INSERT) begin
        accepted_q    <= ins;
        position_q    <= ins ? PosWidth'(pos) : '0;
        present_q     <= 1'b0;
        entry_score_q <= '0;
        entry_key_q   <= '0;
        entry_tag_q   <= '0;
      end else begin
        accepted_q    <= 1'b0;
        position_q    <= '0;
        present_q     <= hit_q;
        entry_score_q <= hit_q ? rd_score_q : '0;
        entry_key_q   <= hit_q ? rd_key_q : '0;
        entry_tag_q   <= hit_q ? rd_tag_q : '0;
      end
    end
  end

  assign accepted_o    = accepted_q;
  assign position_o    = position_q;
  assign count_o       = CountWidth'(count_q);
  assign present_o     = present_q;
  assign entry_score_o = entry_score_q;
  assign entry_key_o   = entry_key_q;
  assign entry_tag_o   = TagPortW'(entry_tag_q);

endmodule

@@ hdl/top_k_smallest_selector.sv @@
// Keeps the CAPACITY best (score, key, tag) entries seen so far, sorted ascending by
// score with ties going to the smaller key. An insert (op 0) offers an entry: it is
// appended while the list has room, otherwise it replaces the last entry only if it
// ranks strictly better, and it lands in its sorted slot; the result gives accepted,
// position and the new count. A read (op 1) returns the entry at index with present
// set when index is below count. The transaction is captured at its accepting edge,
// then a parallel rank compare of all slots is registered, and then the slot row
// shift is done together with the result registers, which then hold a valid result;
// it then waits for as long as out_ready_i is held low. The block takes the next
// transaction in the cycle after the result has been taken, and none while one is
// in flight. The count comes up as zero after reset; no clearing pass.
module top_k_smallest_selector
  import tksel_pkg::*;
#(
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned TAG_WIDTH = TagWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [ScoreWidth-1:0] score_i,
  input  logic [KeyWidth-1:0]   key_i,
  input  logic [TagPortW-1:0]   tag_i,
  input  logic [IndexWidth-1:0] index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  accepted_o,
  output logic [PosWidth-1:0]   position_o,
  output logic [CountWidth-1:0] count_o,
  output logic                  present_o,
  output logic [ScoreWidth-1:0] entry_score_o,
  output logic [KeyWidth-1:0]   entry_key_o,
  output logic [TagPortW-1:0]   entry_tag_o
);

  tksel_cmd_t cmd;

  // sequencing
  tksel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // sorted slot row and result registers
  tksel_dp #(
    .CAPACITY  (CAPACITY),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_i),
    .score_i       (score_i),
    .key_i         (key_i),
    .tag_i         (tag_i),
    .index_i       (index_i),
    .accepted_o    (accepted_o),
    .position_o    (position_o),
    .count_o       (count_o),
    .present_o     (present_o),
    .entry_score_o (entry_score_o),
    .entry_key_o   (entry_key_o),
    .entry_tag_o   (entry_tag_o)
  );

endmodule
